// File: sv/isot_pkg.sv
// Shared constants and types for the insertion-ordered set table.
// No dependencies; imported by the interfaces, the cell, the top level and the checker.
`default_nettype none

package isot_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam int FUNC_W   = 3;
	localparam int ELEM_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 3;

	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp;   // command transfer: latch the compare result
		logic exe;   // result commit: update stored entries
		logic rm;    // remove: a matching cell starts the shift
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/isot_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on isot_pkg.
`default_nettype none

interface isot_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [isot_pkg::FUNC_W-1:0]           func;
	logic signed [isot_pkg::ELEM_W-1:0]    elem;

	modport source (output valid, output func, output elem, input ready);
	modport sink   (input valid, input func, input elem, output ready);
endinterface

interface isot_res_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  member;
	logic signed [isot_pkg::ELEM_W-1:0]    value;
	logic [isot_pkg::COUNT_W-1:0]          count;
	logic                                  empty_res;
	logic [isot_pkg::STATUS_W-1:0]         status;

	modport source (output valid, output member, output value, output count,
		output empty_res, output status, input ready);
	modport sink   (input valid, input member, input value, input count,
		input empty_res, input status, output ready);
endinterface

`default_nettype wire

// File: sv/insertion_ordered_set_table.sv
// Channel  Dir   Transfer when       Payload
// cmd      in    valid && ready      func, elem
// res      out   valid && ready      member, value, count, empty_res, status
//
// One command at a time: all cells compare on the command transfer; the
// commit in S_EXE then applies the update (append, shift-down compaction or
// clear) and loads the result register. The shift chain through the cells
// sets the commit path. Reset empties the table at once; no sweep is needed.
// A stalled result holds the commit; cmd.ready stays low until it is taken.
// Depends on isot_pkg, isot_if and isot_cell.
`default_nettype none

module insertion_ordered_set_table (
	input  wire        clk,
	input  wire        arst_n,
	isot_cmd_if.sink   cmd,
	isot_res_if.source res
);
	import isot_pkg::*;

	typedef enum logic {S_IDLE, S_EXE} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         fill_q;
	logic [FUNC_W-1:0]        func_q;
	logic signed [ELEM_W-1:0] elem_q;

	logic                     res_valid_q;
	logic                     member_q;
	logic signed [ELEM_W-1:0] value_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     empty_q;
	logic [STATUS_W-1:0]      status_q;

	value_t      entry [CAPACITY];
	logic        hit   [CAPACITY];
	logic        chain [CAPACITY+1];
	cell_ctl_t   ctl;
	value_t      cmp_val;
	value_t      wr_val;

	logic                     fire;
	logic                     found;
	logic                     add_go;
	logic                     pop_go;
	logic                     member_w;
	logic signed [ELEM_W-1:0] value_w;
	logic [STATUS_W-1:0]      status_w;
	logic [CNT_W-1:0]         fill_w;

	assign cmd.ready = (state_q == S_IDLE);
	assign fire      = (state_q == S_EXE) && (!res_valid_q || res.ready);

	assign cmp_val = VALUE_WIDTH'($unsigned(cmd.elem));
	assign wr_val  = VALUE_WIDTH'($unsigned(elem_q));

	assign ctl.cmp = cmd.valid && cmd.ready;
	assign ctl.exe = fire;
	assign ctl.rm  = (func_q == FN_REMOVE);

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | hit[i];
		end
	end

	assign add_go = (func_q == FN_ADD) && !found && (fill_q < CNT_W'(CAPACITY));
	assign pop_go = (func_q == FN_POP) && (fill_q != '0);
	assign chain[0] = pop_go;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		value_t next_val;
		if (g == CAPACITY - 1) begin : g_last
			assign next_val = '0;
		end else begin : g_mid
			assign next_val = entry[g+1];
		end
		isot_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (fill_q > CNT_W'(g)),
			.wr        (add_go && (fill_q == CNT_W'(g))),
			.cmp_val   (cmp_val),
			.wr_val    (wr_val),
			.next_val  (next_val),
			.shift_in  (chain[g]),
			.shift_out (chain[g+1]),
			.hit       (hit[g]),
			.entry     (entry[g])
		);
	end

	always_comb begin
		member_w = 1'b0;
		value_w  = elem_q;
		status_w = ST_DONE;
		fill_w   = fill_q;
		unique case (func_q)
			FN_ADD: begin
				if (found) begin
					member_w = 1'b1;
					status_w = ST_PRESENT;
				end else if (!add_go) begin
					status_w = ST_FULL;
				end else begin
					fill_w = fill_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (found) begin
					member_w = 1'b1;
					fill_w   = fill_q - CNT_W'(1);
				end else begin
					status_w = ST_ABSENT;
				end
			end
			FN_QUERY: begin
				member_w = found;
				status_w = found ? ST_DONE : ST_ABSENT;
			end
			FN_POP: begin
				if (pop_go) begin
					member_w = 1'b1;
					value_w  = ELEM_W'(entry[0]);
					fill_w   = fill_q - CNT_W'(1);
				end else begin
					value_w  = '0;
					status_w = ST_EMPTY;
				end
			end
			FN_CLEAR: begin
				fill_w = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_EXE;
					end
				end
				S_EXE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				fill_q      <= fill_w;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			func_q <= cmd.func;
			elem_q <= cmd.elem;
		end
		if (fire) begin
			member_q <= member_w;
			value_q  <= value_w;
			count_q  <= COUNT_W'(fill_w);
			empty_q  <= (fill_w == '0);
			status_q <= status_w;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.member    = member_q;
	assign res.value     = value_q;
	assign res.count     = count_q;
	assign res.empty_res = empty_q;
	assign res.status    = status_q;

endmodule

`default_nettype wire

// File: sv/isot_cell.sv
// One slot of the set table: stored entry, match flag and shift link to its neighbor.
// Depends on isot_pkg.
`default_nettype none

module isot_cell (
	input  wire                 clk,
	input  isot_pkg::cell_ctl_t ctl,
	input  wire                 valid,
	input  wire                 wr,
	input  isot_pkg::value_t    cmp_val,
	input  isot_pkg::value_t    wr_val,
	input  isot_pkg::value_t    next_val,
	input  wire                 shift_in,
	output logic                shift_out,
	output logic                hit,
	output isot_pkg::value_t    entry
);
	import isot_pkg::*;

	value_t entry_q;
	logic   hit_q;
	logic   shift;

	// Once a cell shifts, every later cell shifts too.
	assign shift     = shift_in | (ctl.rm & hit_q);
	assign shift_out = shift;
	assign hit       = hit_q;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q <= valid && (entry_q == cmp_val);
		end
		if (ctl.exe) begin
			if (wr) begin
				entry_q <= wr_val;
			end else if (shift) begin
				entry_q <= next_val;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/isot_chk.sv
// Port-level checker for the set table, bound to the top level.
// Depends on isot_pkg; sees the channel signals only.
`default_nettype none

module isot_chk (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 res_valid,
	input wire                                 res_ready,
	input wire                                 res_member,
	input wire [isot_pkg::ELEM_W-1:0]          res_value,
	input wire [isot_pkg::COUNT_W-1:0]         res_count,
	input wire                                 res_empty,
	input wire [isot_pkg::STATUS_W-1:0]        res_status
);
	import isot_pkg::*;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_empty == (res_count == '0)))
		else $error("empty_res disagrees with count");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_EMPTY) |->
		(!res_member && res_value == '0 && res_count == '0))
		else $error("empty pop result malformed");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_FULL) |->
		(!res_member && res_count == COUNT_W'(CAPACITY)))
		else $error("full drop without a full table");

	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_PRESENT) |-> res_member)
		else $error("already-present without membership");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_count)
		&& $stable(res_status) && $stable(res_value)))
		else $error("stalled result changed");

endmodule

bind insertion_ordered_set_table isot_chk u_isot_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_member (res.member),
	.res_value  (res.value),
	.res_count  (res.count),
	.res_empty  (res.empty_res),
	.res_status (res.status)
);

`default_nettype wire
